// ===== rtl/fcp_pkg.sv =====
package fcp_pkg;

    localparam int STORE_BYTES  = 50;
    localparam int FILL_LIMIT   = STORE_BYTES - 2;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int POS_W        = $clog2(STORE_BYTES + 2);
    localparam int RESULT_LIMIT = 24;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
    localparam int TIME_W       = 31;
    localparam int KIND_W       = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam logic [KIND_W-1:0] KIND_PUMP    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LAMP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HEATING = 3'd2;
    localparam logic [KIND_W-1:0] KIND_VENT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIME    = 3'd4;

endpackage

// ===== rtl/framed_command_parser.sv =====
// Channel   Signals                                              Direction
// request   start, busy, rx_byte                                 in (busy out)
// result    result_valid, command_kind, switch_on,               out
//           time_value, last_of_message
//
// An ordinary byte is taken and busy stays low.
// A backslash closing a message starts the scan: busy is high while the
// sequencer walks the store after the star, each byte by a registered
// read of the message store, then decode, until the scan closes.
// Each result strobes for one cycle; the receiver cannot stall.
// Reset clears the sequencer, the fill count, the message flag and the valid flags.
module framed_command_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [7:0]                        rx_byte,
    output logic                              result_valid,
    output logic [fcp_pkg::KIND_W-1:0]        command_kind,
    output logic                              switch_on,
    output logic [fcp_pkg::TIME_W-1:0]        time_value,
    output logic                              last_of_message
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_KEY_RD = 3'd1;
    localparam logic [2:0] ST_KEY    = 3'd2;
    localparam logic [2:0] ST_VAL_RD = 3'd3;
    localparam logic [2:0] ST_FLAG   = 3'd4;
    localparam logic [2:0] ST_DIG    = 3'd5;

    logic [7:0] store_mem [fcp_pkg::STORE_BYTES];

    logic [2:0]                     state_reg, state_next;
    logic [fcp_pkg::POS_W-1:0]      fill_reg, fill_next;
    logic                           in_msg_reg, in_msg_next;
    logic [fcp_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [fcp_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [fcp_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [fcp_pkg::TIME_W-1:0]     acc_reg, acc_next;
    logic [7:0]                     rd_data_reg;

    logic                           pend_valid_reg, pend_valid_next;
    logic [fcp_pkg::KIND_W-1:0]     pend_kind_reg, pend_kind_next;
    logic                           pend_on_reg, pend_on_next;
    logic [fcp_pkg::TIME_W-1:0]     pend_time_reg, pend_time_next;

    logic                           out_valid_reg, out_valid_next;
    logic [fcp_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic                           out_on_reg, out_on_next;
    logic [fcp_pkg::TIME_W-1:0]     out_time_reg, out_time_next;
    logic                           out_last_reg, out_last_next;

    logic                           accept;
    logic                           wr_en;
    logic [fcp_pkg::POS_W-1:0]      wr_pos;
    logic                           rd_en;
    logic                           produce;
    logic                           finish;
    logic [fcp_pkg::KIND_W-1:0]     new_kind;
    logic                           new_on;
    logic [fcp_pkg::TIME_W-1:0]     new_time;
    logic [fcp_pkg::TIME_W-1:0]     acc_step;
    logic                           is_digit;
    logic                           pos_past;

    fcp_dec_acc u_acc
    (
        .acc      (acc_reg),
        .digit    (rd_data_reg[3:0]),
        .acc_next (acc_step)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign pos_past = (pos_reg >= fill_reg);

    always_comb
    begin
        is_digit = rd_data_reg inside {[fcp_pkg::CH_0:fcp_pkg::CH_9]};
    end

    // receive side
    always_comb
    begin
        in_msg_next = in_msg_reg;
        fill_next   = fill_reg;
        wr_en       = 1'b0;
        wr_pos      = fill_reg;
        if (accept)
        begin
            if (rx_byte == fcp_pkg::CH_STAR)
            begin
                wr_en       = 1'b1;
                wr_pos      = '0;
                in_msg_next = 1'b1;
                fill_next   = fcp_pkg::POS_W'(1);
            end
            else if (in_msg_reg)
            begin
                if (rx_byte == fcp_pkg::CH_BSL)
                    in_msg_next = 1'b0;
                else if (fill_reg < fcp_pkg::POS_W'(fcp_pkg::FILL_LIMIT))
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + fcp_pkg::POS_W'(1);
                end
            end
        end
    end

    // scan sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        rd_en      = 1'b0;
        produce    = 1'b0;
        finish     = 1'b0;
        new_kind   = kind_reg;
        new_on     = 1'b0;
        new_time   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_msg_reg && rx_byte == fcp_pkg::CH_BSL)
                begin
                    state_next = ST_KEY_RD;
                    pos_next   = fcp_pkg::POS_W'(1);
                    cnt_next   = '0;
                end
            end
            ST_KEY_RD:
            begin
                if (pos_past || cnt_reg == fcp_pkg::CNT_W'(fcp_pkg::RESULT_LIMIT))
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_KEY;
                end
            end
            ST_KEY:
            begin
                state_next = ST_VAL_RD;
                pos_next   = pos_reg + fcp_pkg::POS_W'(2);
                acc_next   = '0;
                case (rd_data_reg)
                    fcp_pkg::CH_P: kind_next = fcp_pkg::KIND_PUMP;
                    fcp_pkg::CH_L: kind_next = fcp_pkg::KIND_LAMP;
                    fcp_pkg::CH_H: kind_next = fcp_pkg::KIND_HEATING;
                    fcp_pkg::CH_V: kind_next = fcp_pkg::KIND_VENT;
                    fcp_pkg::CH_T: kind_next = fcp_pkg::KIND_TIME;
                    default:
                    begin
                        state_next = ST_KEY_RD;
                        pos_next   = pos_reg + fcp_pkg::POS_W'(1);
                    end
                endcase
            end
            ST_VAL_RD:
            begin
                if (pos_past)
                begin
                    produce    = 1'b1;
                    new_time   = (kind_reg == fcp_pkg::KIND_TIME) ? acc_reg : '0;
                    state_next = ST_KEY_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = (kind_reg == fcp_pkg::KIND_TIME) ? ST_DIG : ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                produce    = 1'b1;
                new_on     = (rd_data_reg == fcp_pkg::CH_1);
                pos_next   = pos_reg + fcp_pkg::POS_W'(1);
                state_next = ST_KEY_RD;
            end
            ST_DIG:
            begin
                if (is_digit)
                begin
                    acc_next   = acc_step;
                    pos_next   = pos_reg + fcp_pkg::POS_W'(1);
                    state_next = ST_VAL_RD;
                end
                else
                begin
                    produce    = 1'b1;
                    new_time   = acc_reg;
                    state_next = ST_KEY_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (produce)
            cnt_next = cnt_reg + fcp_pkg::CNT_W'(1);
    end

    // one result held back so the final one can carry the last mark
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_on_next    = pend_on_reg;
        pend_time_next  = pend_time_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = pend_kind_reg;
        out_on_next     = pend_on_reg;
        out_time_next   = pend_time_reg;
        out_last_next   = 1'b0;
        if (produce)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_kind_next  = new_kind;
            pend_on_next    = new_on;
            pend_time_next  = new_time;
        end
        else if (finish)
        begin
            out_valid_next  = pend_valid_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_pos[fcp_pkg::ADDR_W-1:0]] <= rx_byte;
        if (rd_en)
            rd_data_reg <= store_mem[pos_reg[fcp_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            in_msg_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            in_msg_reg     <= in_msg_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        kind_reg      <= kind_next;
        acc_reg       <= acc_next;
        pend_kind_reg <= pend_kind_next;
        pend_on_reg   <= pend_on_next;
        pend_time_reg <= pend_time_next;
        out_kind_reg  <= out_kind_next;
        out_on_reg    <= out_on_next;
        out_time_reg  <= out_time_next;
        out_last_reg  <= out_last_next;
    end

    assign result_valid    = out_valid_reg;
    assign command_kind    = out_kind_reg;
    assign switch_on       = out_on_reg;
    assign time_value      = out_time_reg;
    assign last_of_message = out_last_reg;

endmodule

// ===== rtl/fcp_dec_acc.sv =====
module fcp_dec_acc
(
    input  logic [fcp_pkg::TIME_W-1:0] acc,
    input  logic [3:0]                 digit,
    output logic [fcp_pkg::TIME_W-1:0] acc_next
);

    logic [fcp_pkg::TIME_W+3:0] sum;

    // acc * 10 + digit, saturating
    always_comb
    begin
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
            + {{(fcp_pkg::TIME_W){1'b0}}, digit};
        if (sum[fcp_pkg::TIME_W+3:fcp_pkg::TIME_W] != 4'd0)
            acc_next = fcp_pkg::TIME_MAX;
        else
            acc_next = sum[fcp_pkg::TIME_W-1:0];
    end

endmodule
